/* rtl/ctc_pkg.sv */
// ----------------------------------------------------------------------------
// ctc_pkg
// Types and constants shared by the compact target codec modules.
// ----------------------------------------------------------------------------
package ctc_pkg;

   localparam int unsigned ValueWidth   = 256;
   localparam int unsigned ValueBytes   = ValueWidth / 8;
   localparam int unsigned CompactWidth = 32;
   localparam int unsigned MantWidth    = 23;
   localparam int unsigned SizeWidth    = 8;
   localparam int unsigned LenWidth     = $clog2(ValueBytes + 1);

   localparam logic OP_DECODE = 1'b0;
   localparam logic OP_ENCODE = 1'b1;

   // Mantissa thresholds used for the decode overflow check.
   localparam logic [MantWidth-1:0] MantOneByte = 23'h0000ff;
   localparam logic [MantWidth-1:0] MantTwoByte = 23'h00ffff;

   // Size limits above which a nonzero mantissa no longer fits in 256 bits.
   localparam logic [SizeWidth-1:0] SizeLimit1 = 8'd34;
   localparam logic [SizeWidth-1:0] SizeLimit2 = 8'd33;
   localparam logic [SizeWidth-1:0] SizeLimit3 = 8'd32;

   typedef struct packed {
      logic        op;
      logic [31:0] compact_in;
      logic [63:0] value_in_w3;
      logic [63:0] value_in_w2;
      logic [63:0] value_in_w1;
      logic [63:0] value_in_w0;
      logic        sign_in;
   } req_type;

   typedef struct packed {
      logic [63:0] value_out_w3;
      logic [63:0] value_out_w2;
      logic [63:0] value_out_w1;
      logic [63:0] value_out_w0;
      logic [31:0] compact_out;
      logic        is_negative;
      logic        is_overflow;
   } rsp_type;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  negative;
      logic                  overflow;
   } dec_result_type;

endpackage

/* rtl/ctc_dec.sv */
// ----------------------------------------------------------------------------
// ctc_dec
// Expands a compact word into a 256-bit value with sign and overflow flags.
// ----------------------------------------------------------------------------
module ctc_dec
   import ctc_pkg::*;
(
   input  logic [CompactWidth-1:0] compact,
   output dec_result_type          result
);

   logic [SizeWidth-1:0] size;
   logic [MantWidth-1:0] mant_raw;
   logic [MantWidth-1:0] mant;
   logic [SizeWidth-1:0] lshift_bytes;
   logic [ValueWidth-1:0] wide_mant;
   logic                 mant_nz;

   assign size     = compact[31:24];
   assign mant_raw = compact[MantWidth-1:0];

   // Small sizes drop low bytes of the mantissa.
   always_comb begin
      case (size)
         8'd0:    mant = '0;
         8'd1:    mant = mant_raw >> 16;
         8'd2:    mant = mant_raw >> 8;
         default: mant = mant_raw;
      endcase
   end

   assign lshift_bytes = size - 8'd3;
   assign wide_mant    = {{(ValueWidth-MantWidth){1'b0}}, mant};
   assign mant_nz      = (mant != '0);

   always_comb begin
      if (size <= 8'd3) begin
         result.value = wide_mant;
      end else if (lshift_bytes >= 8'(ValueBytes)) begin
         result.value = '0;
      end else begin
         result.value = wide_mant << {lshift_bytes[LenWidth-2:0], 3'b000};
      end
      result.negative = mant_nz & compact[MantWidth];
      result.overflow = mant_nz & ((size > SizeLimit1) ||
                                   ((mant > MantOneByte) && (size > SizeLimit2)) ||
                                   ((mant > MantTwoByte) && (size > SizeLimit3)));
   end

endmodule

/* rtl/ctc_enc.sv */
// ----------------------------------------------------------------------------
// ctc_enc
// Packs a 256-bit value into the compact word form.
// ----------------------------------------------------------------------------
module ctc_enc
   import ctc_pkg::*;
(
   input  logic [ValueWidth-1:0]   value,
   input  logic                    sign,
   output logic [CompactWidth-1:0] compact
);

   localparam int unsigned PadWidth = ValueWidth + 24;

   logic [LenWidth-1:0]  len;
   logic [PadWidth-1:0]  padded;
   logic [PadWidth-1:0]  window;
   logic [23:0]          mant24;
   logic [MantWidth-1:0] mant;
   logic [SizeWidth-1:0] size;

   // Byte length: index of the highest nonzero byte plus one.
   always_comb begin
      len = '0;
      for (int i = 0; i < ValueBytes; i++) begin
         if (|value[8*i +: 8]) begin
            len = LenWidth'(i + 1);
         end
      end
   end

   // Three zero bytes below the value let one shift cover every size: the
   // window starting at byte len holds value bytes len-3 .. len-1.
   assign padded = {value, 24'h000000};
   assign window = padded >> {len, 3'b000};
   assign mant24 = window[23:0];

   always_comb begin
      if (mant24[23]) begin
         mant = MantWidth'(mant24 >> 8);
         size = SizeWidth'(len) + 8'd1;
      end else begin
         mant = mant24[MantWidth-1:0];
         size = SizeWidth'(len);
      end
      compact = {size, sign & (mant != '0), mant};
   end

endmodule

/* rtl/compact_target_codec_core.sv */
// ----------------------------------------------------------------------------
// compact_target_codec_core
// Converts between 256-bit targets and their 32-bit compact encoding.
// ----------------------------------------------------------------------------
// Each request transaction carries an op bit: decode expands compact_in into a
// 256-bit value with negative and overflow flags, encode packs the value words
// into a compact word, with the sign bit set when sign_in is high and the
// mantissa is nonzero. Fields that do not belong to the chosen op read as zero.
// A transaction is captured in an input register, converted by one pass of
// combinational logic (a byte barrel shifter for decode, a leading-byte search
// and byte selector for encode) and stored in a result register. The response
// becomes valid once the transaction has passed the input register and the
// result register, and one transaction can be accepted every cycle while the
// response side keeps up. Both stages advance only when the stage after them
// has room, so a stalled response holds back the input register and then
// req_ready.
module compact_target_codec_core
   import ctc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Input stage.
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;

   // Result stage.
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;

   logic out_load;
   logic in_load;

   dec_result_type          dec_result;
   logic [CompactWidth-1:0] enc_compact;

   // The result register takes a new transaction when it is empty or its
   // current one leaves this cycle; the input register likewise.
   assign out_load  = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | out_load;
   assign in_load   = req_valid & req_ready;

   assign in_valid_in  = in_load | (in_valid_ff & ~out_load);
   assign out_valid_in = out_load | (out_valid_ff & ~rsp_ready);

   ctc_dec u_dec (
      .compact (in_data_ff.compact_in),
      .result  (dec_result)
   );

   ctc_enc u_enc (
      .value   ({in_data_ff.value_in_w3, in_data_ff.value_in_w2,
                 in_data_ff.value_in_w1, in_data_ff.value_in_w0}),
      .sign    (in_data_ff.sign_in),
      .compact (enc_compact)
   );

   // Select the fields for the requested direction and zero the rest.
   always_comb begin
      out_data_in = '0;
      if (in_data_ff.op == OP_ENCODE) begin
         out_data_in.compact_out = enc_compact;
      end else begin
         {out_data_in.value_out_w3, out_data_in.value_out_w2,
          out_data_in.value_out_w1, out_data_in.value_out_w0} = dec_result.value;
         out_data_in.is_negative = dec_result.negative;
         out_data_in.is_overflow = dec_result.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
